@@ hw/rtl/rgb_to_hsv_converter_core_macros.svh @@
// ---------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared property forms for the checker of the converter core.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held
`define RHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, also checked across reset
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rhc_pkg.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV converter package
// Widths, hue offsets and the item record carried along the divider chain.
// ---------------------------------------------------------------------------
package rhc_pkg;

    localparam int ChanW = 8;            // one color channel
    localparam int QuoW  = 8;            // quotient bits, one divider cell each
    localparam int RemW  = ChanW + QuoW; // dividend and partial remainder
    localparam int HueW  = 9;            // hue 0..360
    localparam int InW   = 3 * ChanW;
    localparam int OutW  = 32;           // hue + sat + value padded to bytes
    localparam int ResW  = HueW + 2 * ChanW;

    // hue offsets per sector
    localparam logic [HueW-1:0] HueRedLow  = 9'd0;
    localparam logic [HueW-1:0] HueRedHigh = 9'd360;
    localparam logic [HueW-1:0] HueGreen   = 9'd120;
    localparam logic [HueW-1:0] HueBlue    = 9'd240;

    localparam logic [5:0] HueScale = 6'd60;

    // item as it moves through the divider cells
    typedef struct packed {
        logic [RemW-1:0]  hue_rem;
        logic [ChanW-1:0] hue_div;
        logic [QuoW-1:0]  hue_quo;
        logic [RemW-1:0]  sat_rem;
        logic [ChanW-1:0] sat_div;
        logic [QuoW-1:0]  sat_quo;
        logic             hue_neg;
        logic [HueW-1:0]  hue_base;
        logic [ChanW-1:0] value;
    } t_div_data;

endpackage

@@ hw/rtl/rhc_front.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV front stage
// Finds max/min, picks the hue sector and forms both dividends.
// ---------------------------------------------------------------------------
module rhc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rhc_pkg::InW-1:0]     i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rhc_pkg::t_div_data          o_data
);
    import rhc_pkg::*;

    logic [ChanW-1:0] red, green, blue, hi, lo, diff, mag;
    logic             neg;
    logic [HueW-1:0]  base;
    t_div_data        n_data, r_data;
    logic             r_valid;

    assign red   = i_pixel[ChanW-1:0];
    assign green = i_pixel[2*ChanW-1:ChanW];
    assign blue  = i_pixel[3*ChanW-1:2*ChanW];

    // max, min and sector; red wins ties, then green
    always_comb begin
        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi) hi = blue;
        if (green < lo) lo = green;
        if (blue < lo) lo = blue;
        diff = hi - lo;
        if (hi == red) begin
            if (green >= blue) begin
                mag  = green - blue;
                neg  = 1'b0;
                base = HueRedLow;
            end else begin
                mag  = blue - green;
                neg  = 1'b1;
                base = HueRedHigh;
            end
        end else if (hi == green) begin
            neg  = (blue < red);
            mag  = neg ? (red - blue) : (blue - red);
            base = HueGreen;
        end else begin
            neg  = (red < green);
            mag  = neg ? (green - red) : (red - green);
            base = HueBlue;
        end
    end

    // dividends; a zero divisor only meets a zero dividend, so use 1 there
    always_comb begin
        n_data          = '0;
        n_data.hue_rem  = RemW'(mag) * RemW'(HueScale);
        n_data.hue_div  = (diff == '0) ? ChanW'(1) : diff;
        n_data.sat_rem  = {diff, {ChanW{1'b0}}} - RemW'(diff);
        n_data.sat_div  = (hi == '0) ? ChanW'(1) : hi;
        n_data.hue_neg  = neg;
        n_data.hue_base = base;
        n_data.value    = hi;
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hw/rtl/rhc_div_cell.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for the hue and saturation lanes.
// ---------------------------------------------------------------------------
module rhc_div_cell #(
    parameter int Bit = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rhc_pkg::t_div_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rhc_pkg::t_div_data o_data
);
    import rhc_pkg::*;

    logic [RemW-1:0] hue_sub, sat_sub;
    logic            hue_ge, sat_ge;
    t_div_data       n_data, r_data;
    logic            r_valid;

    // compare against divisor aligned to this quotient bit
    always_comb begin
        hue_sub = RemW'(i_data.hue_div) << Bit;
        sat_sub = RemW'(i_data.sat_div) << Bit;
        hue_ge  = (i_data.hue_rem >= hue_sub);
        sat_ge  = (i_data.sat_rem >= sat_sub);
        n_data  = i_data;
        n_data.hue_rem      = hue_ge ? (i_data.hue_rem - hue_sub) : i_data.hue_rem;
        n_data.sat_rem      = sat_ge ? (i_data.sat_rem - sat_sub) : i_data.sat_rem;
        n_data.hue_quo[Bit] = hue_ge;
        n_data.sat_quo[Bit] = sat_ge;
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hw/rtl/rhc_back.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV back stage
// Applies the hue offset and sign, and holds the result item.
// ---------------------------------------------------------------------------
module rhc_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rhc_pkg::t_div_data       i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [rhc_pkg::OutW-1:0] o_result
);
    import rhc_pkg::*;

    logic [HueW-1:0] hue;
    logic [OutW-1:0] n_result, r_result;
    logic            r_valid;

    // offset plus or minus the truncated quotient
    always_comb begin
        hue = i_data.hue_neg ? (i_data.hue_base - HueW'(i_data.hue_quo))
                             : (i_data.hue_base + HueW'(i_data.hue_quo));
        n_result = OutW'({i_data.value, i_data.sat_quo, hue});
    end

    assign o_ready = !r_valid || i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/rgb_to_hsv_converter_core.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV converter core
// 8-bit RGB pixel in, integer HSV out, one pixel per clock when not stalled.
// ---------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls and returns one result
// per pixel, in order. Input passes through one stage for max/min and
// dividends, eight divider cells (one quotient bit each, hue and saturation
// in parallel lanes), and the output register. Every stage has its own
// valid and accepts when empty or when it drains, so bubbles close up and
// the input keeps flowing while an output result waits, until all are full.
// Hue is 0..360 (0 for grey), saturation is 255*(max-min)/max truncated
// (0 for black), value is the largest channel.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic [rhc_pkg::InW-1:0]  i_s_tdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [8:0] hue_out, [16:9] sat_out, [24:17] value_out, [31:25] zero
    output logic [rhc_pkg::OutW-1:0] o_m_tdata
);
    import rhc_pkg::*;

    t_div_data stage_data  [0:QuoW];
    logic      stage_valid [0:QuoW];
    logic      stage_ready [0:QuoW];

    // sector, max/min, dividends
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pixel (i_s_tdata),
        .o_valid (stage_valid[0]),
        .i_ready (stage_ready[0]),
        .o_data  (stage_data[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < QuoW; k++) begin : g_cell
        rhc_div_cell #(
            .Bit (QuoW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[k]),
            .o_ready (stage_ready[k]),
            .i_data  (stage_data[k]),
            .o_valid (stage_valid[k+1]),
            .i_ready (stage_ready[k+1]),
            .o_data  (stage_data[k+1])
        );
    end

    // hue offset and output register
    rhc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid[QuoW]),
        .o_ready  (stage_ready[QuoW]),
        .i_data   (stage_data[QuoW]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (o_m_tdata)
    );

endmodule

@@ hw/rtl/rhc_checker.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV converter checker
// Port-level assertions on the result stream, bound to the core.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_converter_core_macros.svh"

module rhc_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [rhc_pkg::OutW-1:0] o_m_tdata
);
    import rhc_pkg::*;

    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat, value;

    assign hue   = o_m_tdata[HueW-1:0];
    assign sat   = o_m_tdata[HueW+ChanW-1:HueW];
    assign value = o_m_tdata[ResW-1:HueW+ChanW];

    // reset empties the output
    `RHC_ASSERT_NEXT(a_reset_empty, !i_rst_n, !o_m_tvalid, "output valid after reset")

    // stalled result holds
    `RHC_ASSERT_NEXT(a_stall_hold, i_rst_n && o_m_tvalid && !i_m_tready,
                     o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // hue range and zero padding
    `RHC_ASSERT_IMP(a_hue_range, o_m_tvalid,
                    hue <= HueRedHigh && o_m_tdata[OutW-1:ResW] == '0, "hue out of range")

    // black pixel: no saturation, no hue
    `RHC_ASSERT_IMP(a_black, o_m_tvalid && value == '0,
                    sat == '0 && hue == '0, "black pixel with hue or saturation")

    // saturation full only when min is zero; any saturation needs a nonzero value
    `RHC_ASSERT_IMP(a_sat_value, o_m_tvalid && sat != '0, value != '0,
                    "saturation without value")

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ dv/rgb_to_hsv_converter_core_test.sv @@
// ---------------------------------------------------------------------------
// RGB to HSV converter core testbench
// Streams pixels into the core with bursty input and a stalling output side,
// predicts hue, saturation and value for each accepted pixel, and compares
// every returned item field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module rgb_to_hsv_converter_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    localparam int NumRandom  = 850;
    localparam int CycleLimit = 400000;
    localparam int DrainWait  = 24;     // pipeline is 10 deep, plus margin

    // one predicted result
    typedef struct packed {
        logic [HueW-1:0]  hue;
        logic [ChanW-1:0] sat;
        logic [ChanW-1:0] value;
    } t_hsv;

    // Holds predicted results in order and checks returned items against them
    class hsv_scoreboard;
        t_hsv expected_hsv[$];
        int   fails;

        function new();
            fails = 0;
        endfunction

        // integer HSV of one pixel
        function t_hsv hsv_of(logic [ChanW-1:0] red, logic [ChanW-1:0] grn,
                              logic [ChanW-1:0] blu);
            int   r, g, b, hi, lo, d, hue, sat;
            t_hsv res;
            r  = int'(red);
            g  = int'(grn);
            b  = int'(blu);
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            d = hi - lo;
            // grey gives hue zero; red wins ties, then green
            if (d == 0) begin
                hue = 0;
            end else if (hi == r) begin
                hue = (int'(HueScale) * (g - b)) / d
                    + ((g >= b) ? int'(HueRedLow) : int'(HueRedHigh));
            end else if (hi == g) begin
                hue = (int'(HueScale) * (b - r)) / d + int'(HueGreen);
            end else begin
                hue = (int'(HueScale) * (r - g)) / d + int'(HueBlue);
            end
            // black gives saturation zero
            sat = (hi == 0) ? 0 : (255 * d) / hi;
            res.hue   = hue[HueW-1:0];
            res.sat   = sat[ChanW-1:0];
            res.value = hi[ChanW-1:0];
            return res;
        endfunction

        function void note_pixel(logic [InW-1:0] px);
            expected_hsv.push_back(hsv_of(px[7:0], px[15:8], px[23:16]));
        endfunction

        function void check_result(logic [OutW-1:0] word);
            t_hsv exp_res;
            if (expected_hsv.size() == 0) begin
                $display("%0t: unexpected item, actual %h", $time, word);
                fails++;
                return;
            end
            exp_res = expected_hsv.pop_front();
            if (word[8:0] !== exp_res.hue) begin
                $display("%0t: hue mismatch, expected %0d actual %0d",
                         $time, exp_res.hue, word[8:0]);
                fails++;
            end
            if (word[16:9] !== exp_res.sat) begin
                $display("%0t: sat mismatch, expected %0d actual %0d",
                         $time, exp_res.sat, word[16:9]);
                fails++;
            end
            if (word[24:17] !== exp_res.value) begin
                $display("%0t: value mismatch, expected %0d actual %0d",
                         $time, exp_res.value, word[24:17]);
                fails++;
            end
            if (word[31:25] !== 7'd0) begin
                $display("%0t: padding mismatch, expected 0 actual %h",
                         $time, word[31:25]);
                fails++;
            end
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_s_tvalid = 1'b0;
    logic            o_s_tready;
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    logic [InW-1:0]  i_s_tdata  = '0;
    logic            o_m_tvalid;
    logic            i_m_tready = 1'b0;
    // [8:0] hue_out, [16:9] sat_out, [24:17] value_out, [31:25] zero
    logic [OutW-1:0] o_m_tdata;

    int              cycles     = 0;
    logic [1:0]      rx_mode    = 2'd0;

    hsv_scoreboard   sb = new();

    rgb_to_hsv_converter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // cycle count and run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: check accepted items, stall on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
        if (cycles % 97 == 0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0: i_m_tready <= 1'b1;
            2'd1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic logic [InW-1:0] rgb(int r, int g, int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    // random pixel, weighted toward grey, ties, tiny spans and extremes
    function automatic logic [InW-1:0] random_pixel();
        int         pick;
        logic [7:0] a, c, e;
        pick = $urandom_range(0, 99);
        a = 8'($urandom);
        c = 8'($urandom);
        e = 8'($urandom);
        if (pick < 50) return 24'($urandom);
        if (pick < 62) return {a, a, a};
        if (pick < 77) begin
            case ($urandom_range(0, 2))
                0: return {c, a, a};
                1: return {a, c, a};
                default: return {a, a, c};
            endcase
        end
        if (pick < 87) return {6'd0, e[1:0], 6'd0, c[1:0], 6'd0, a[1:0]};
        // each channel at or near one end of the range
        return {(e[0] ? 8'hff - {7'd0, e[1]} : {7'd0, e[2]}),
                (c[0] ? 8'hff - {7'd0, c[1]} : {7'd0, c[2]}),
                (a[0] ? 8'hff - {7'd0, a[1]} : {7'd0, a[2]})};
    endfunction

    // present one pixel and hold it until accepted
    task automatic send_pixel(input logic [InW-1:0] px);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_pixel(px);
    endtask

    // drop valid for a random gap, with noise on the data lines
    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 24'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    logic [InW-1:0] directed[$];

    initial begin
        int left, burst;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // black, white, grey, primaries, ties, hue wrap, tiny spans
        directed = '{rgb(0, 0, 0), rgb(255, 255, 255), rgb(128, 128, 128),
                     rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
                     rgb(255, 255, 0), rgb(0, 255, 255), rgb(255, 0, 255),
                     rgb(255, 0, 1), rgb(1, 0, 0), rgb(0, 1, 0),
                     rgb(0, 0, 1), rgb(1, 0, 1), rgb(1, 1, 0),
                     rgb(255, 254, 0), rgb(254, 255, 0), rgb(255, 1, 254),
                     rgb(17, 200, 33), rgb(200, 13, 99), rgb(0, 128, 255),
                     rgb(255, 0, 128), rgb(255, 128, 128), rgb(1, 1, 1)};
        foreach (directed[k]) begin
            send_pixel(directed[k]);
            if ($urandom_range(0, 2) == 0) idle_gap();
        end

        // random bursts
        left = NumRandom;
        while (left > 0) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
                send_pixel(random_pixel());
                burst--;
                left--;
            end
            if (left > 0) idle_gap();
        end
        i_s_tvalid <= 1'b0;

        // drain
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
